### src/ihy_pkg.sv
// ----------------------------------------------------------------------------
// ihy_pkg
// Shared types, constants and the arctangent table for the heading/yaw unit.
// ----------------------------------------------------------------------------
package ihy_pkg;

  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DATA_W           = 46;
  localparam int BAM_W            = 16;
  localparam int Z_W              = 32;

  localparam logic [7:0] ID_MAG      = 8'h04;
  localparam logic [7:0] ID_GRV      = 8'h08;
  localparam logic [7:0] MIN_LEN_MAG = 8'd6;
  localparam logic [7:0] MIN_LEN_GRV = 8'd8;

  localparam int Q28_ONE = 1 << 28;

  localparam logic [BAM_W-1:0] BAM_ZERO    = 16'h0000;
  localparam logic [BAM_W-1:0] BAM_QUARTER = 16'h4000;
  localparam logic [BAM_W-1:0] BAM_HALF    = 16'h8000;
  localparam logic [BAM_W-1:0] BAM_3QUART  = 16'hC000;

  localparam logic [Z_W-1:0] Z_ZERO  = 32'h0000_0000;
  localparam logic [Z_W-1:0] Z_HALF  = 32'h8000_0000;
  localparam logic [Z_W-1:0] Z_ROUND = 32'h0000_8000;

  typedef struct packed {
    logic                     valid_res;
    logic                     kind;
    logic                     special;
    logic [BAM_W-1:0]         spec_bam;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [Z_W-1:0]           z;
  } cord_t;

  // atan(2^-i), 2^32 units per circle, rounded
  function automatic logic [Z_W-1:0] atan_entry(input int unsigned idx);
    logic [Z_W-1:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### src/ihy_prep.sv
// ----------------------------------------------------------------------------
// ihy_prep
// Three register stages: report decode and products, argument forming,
// axis detection and half-plane pre-rotation.
// ----------------------------------------------------------------------------
module ihy_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic [7:0]          report_id,
  input  logic [7:0]          report_len,
  input  logic signed [15:0]  word_a,
  input  logic signed [15:0]  word_b,
  input  logic signed [15:0]  word_c,
  input  logic signed [15:0]  word_d,
  output logic                m_valid,
  input  logic                m_ready,
  output ihy_pkg::cord_t      m_data
);

  localparam int W = ihy_pkg::DATA_W;

  // stage 1
  logic               v1_r;
  logic               vres1_r, vres1_nxt;
  logic               kind1_r, kind1_nxt;
  logic signed [15:0] a1_r, b1_r;
  logic signed [31:0] pab1_r, pdc1_r, pbb1_r, pcc1_r;
  logic signed [31:0] pab1_nxt, pdc1_nxt, pbb1_nxt, pcc1_nxt;
  logic               en1, is_mag, is_grv;

  // stage 2
  logic               v2_r;
  logic               vres2_r, kind2_r;
  logic signed [W-1:0] x2_r, y2_r, x2_nxt, y2_nxt;
  logic               en2;

  // stage 3
  logic               v3_r;
  ihy_pkg::cord_t     s3_r, s3_nxt;
  logic               en3;

  assign en3     = !v3_r || m_ready;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign s_ready = en1;

  always_comb begin
    is_mag    = (report_id == ihy_pkg::ID_MAG) && (report_len >= ihy_pkg::MIN_LEN_MAG);
    is_grv    = (report_id == ihy_pkg::ID_GRV) && (report_len >= ihy_pkg::MIN_LEN_GRV);
    vres1_nxt = is_mag || is_grv;
    kind1_nxt = is_grv;
    pab1_nxt  = word_a * word_b;
    pdc1_nxt  = word_d * word_c;
    pbb1_nxt  = word_b * word_b;
    pcc1_nxt  = word_c * word_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      vres1_r <= vres1_nxt;
      kind1_r <= kind1_nxt;
      a1_r    <= word_a;
      b1_r    <= word_b;
      pab1_r  <= pab1_nxt;
      pdc1_r  <= pdc1_nxt;
      pbb1_r  <= pbb1_nxt;
      pcc1_r  <= pcc1_nxt;
    end
  end

  // arguments: magnetometer scaled by 2^16, yaw in Q28 scaled by 2^8
  always_comb begin
    if (!vres1_r) begin
      x2_nxt = '0;
      y2_nxt = '0;
    end else if (kind1_r) begin
      y2_nxt = (W'(pdc1_r) + W'(pab1_r)) <<< 9;
      x2_nxt = (W'(ihy_pkg::Q28_ONE) - ((W'(pbb1_r) + W'(pcc1_r)) <<< 1)) <<< 8;
    end else begin
      x2_nxt = W'(a1_r) <<< 16;
      y2_nxt = W'(b1_r) <<< 16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      vres2_r <= vres1_r;
      kind2_r <= kind1_r;
      x2_r    <= x2_nxt;
      y2_r    <= y2_nxt;
    end
  end

  always_comb begin
    s3_nxt.valid_res = vres2_r;
    s3_nxt.kind      = kind2_r;
    s3_nxt.special   = 1'b0;
    s3_nxt.spec_bam  = ihy_pkg::BAM_ZERO;
    if (!vres2_r) begin
      s3_nxt.special = 1'b1;
    end else if (y2_r == '0) begin
      s3_nxt.special  = 1'b1;
      s3_nxt.spec_bam = x2_r[W-1] ? ihy_pkg::BAM_HALF : ihy_pkg::BAM_ZERO;
    end else if (x2_r == '0) begin
      s3_nxt.special  = 1'b1;
      s3_nxt.spec_bam = y2_r[W-1] ? ihy_pkg::BAM_3QUART : ihy_pkg::BAM_QUARTER;
    end
    // left half plane: turn by half a circle
    if (x2_r[W-1]) begin
      s3_nxt.x = -x2_r;
      s3_nxt.y = -y2_r;
      s3_nxt.z = ihy_pkg::Z_HALF;
    end else begin
      s3_nxt.x = x2_r;
      s3_nxt.y = y2_r;
      s3_nxt.z = ihy_pkg::Z_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  assign m_valid = v3_r;
  assign m_data  = s3_r;

endmodule

### src/ihy_cordic_stage.sv
// ----------------------------------------------------------------------------
// ihy_cordic_stage
// One registered vectoring CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
module ihy_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s_valid,
  output logic           s_ready,
  input  ihy_pkg::cord_t s_data,
  output logic           m_valid,
  input  logic           m_ready,
  output ihy_pkg::cord_t m_data
);

  localparam logic [ihy_pkg::Z_W-1:0] ANGLE = ihy_pkg::atan_entry(IDX);

  logic                             v_r;
  ihy_pkg::cord_t                   d_r, d_nxt;
  logic signed [ihy_pkg::DATA_W-1:0] dx, dy;
  logic                             en;

  assign en      = !v_r || m_ready;
  assign s_ready = en;

  always_comb begin
    dx    = s_data.y >>> IDX;
    dy    = s_data.x >>> IDX;
    d_nxt = s_data;
    if (!s_data.y[ihy_pkg::DATA_W-1]) begin
      d_nxt.x = s_data.x + dx;
      d_nxt.y = s_data.y - dy;
      d_nxt.z = s_data.z + ANGLE;
    end else begin
      d_nxt.x = s_data.x - dx;
      d_nxt.y = s_data.y + dy;
      d_nxt.z = s_data.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign m_valid = v_r;
  assign m_data  = d_r;

endmodule

### src/ihy_out.sv
// ----------------------------------------------------------------------------
// ihy_out
// Angle rounding to a 16-bit binary angle and the output register.
// ----------------------------------------------------------------------------
module ihy_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  ihy_pkg::cord_t                s_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_valid_res,
  output logic                          out_kind,
  output logic [ihy_pkg::BAM_W-1:0]     out_bam
);

  logic                         v_r;
  logic                         vres_r, kind_r;
  logic [ihy_pkg::BAM_W-1:0]    bam_r, bam_nxt;
  logic [ihy_pkg::Z_W-1:0]      z_rnd;
  logic                         en;

  assign en      = !v_r || out_ready;
  assign s_ready = en;

  always_comb begin
    z_rnd   = s_data.z + ihy_pkg::Z_ROUND;
    bam_nxt = s_data.special ? s_data.spec_bam
                             : z_rnd[ihy_pkg::Z_W-1 -: ihy_pkg::BAM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vres_r <= s_data.valid_res;
      kind_r <= s_data.kind;
      bam_r  <= bam_nxt;
    end
  end

  assign out_valid     = v_r;
  assign out_valid_res = vres_r;
  assign out_kind      = kind_r;
  assign out_bam       = bam_r;

endmodule

### src/imu_heading_yaw_from_reports.sv
// ----------------------------------------------------------------------------
// imu_heading_yaw_from_reports
// Compass heading and yaw angle from decoded sensor reports.
// ----------------------------------------------------------------------------
// Takes one report item per clock while the output is not stalled and returns
// one result item for each: a magnetometer report gives atan2(y, x) as an
// unsigned binary angle, a game rotation vector report gives the quaternion
// yaw as a signed binary angle, anything else gives an invalid result with a
// zero angle. Each item passes through the three argument stages, one register
// stage per CORDIC iteration (min(CORDIC_STEPS, 24) of them) and the output
// register; the sustained rate is one item per cycle while out_tready is high,
// and each stage only waits when the one after it is full.
module imu_heading_yaw_from_reports #(
  parameter int CORDIC_STEPS = ihy_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // report_len, word_a, word_b, word_c, word_d
  input  logic [7:0]  in_tuser,   // report_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // angle_bam
  output logic [1:0]  out_tuser   // valid_res, angle_kind
);

  localparam int NSTEPS = (CORDIC_STEPS > ihy_pkg::ATAN_ENTRIES) ?
                          ihy_pkg::ATAN_ENTRIES : CORDIC_STEPS;

  logic signed [15:0] word_a, word_b, word_c, word_d;
  ihy_pkg::cord_t     st_data  [0:NSTEPS];
  logic               st_valid [0:NSTEPS];
  logic               st_ready [0:NSTEPS];

  assign word_a = in_tdata[23:8];
  assign word_b = in_tdata[39:24];
  assign word_c = in_tdata[55:40];
  assign word_d = in_tdata[71:56];

  ihy_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (in_tvalid),
    .s_ready    (in_tready),
    .report_id  (in_tuser),
    .report_len (in_tdata[7:0]),
    .word_a     (word_a),
    .word_b     (word_b),
    .word_c     (word_c),
    .word_d     (word_d),
    .m_valid    (st_valid[0]),
    .m_ready    (st_ready[0]),
    .m_data     (st_data[0])
  );

  for (genvar g = 0; g < NSTEPS; g++) begin : g_iter
    ihy_cordic_stage #(
      .IDX (g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .s_valid (st_valid[g]),
      .s_ready (st_ready[g]),
      .s_data  (st_data[g]),
      .m_valid (st_valid[g+1]),
      .m_ready (st_ready[g+1]),
      .m_data  (st_data[g+1])
    );
  end

  ihy_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_valid       (st_valid[NSTEPS]),
    .s_ready       (st_ready[NSTEPS]),
    .s_data        (st_data[NSTEPS]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_valid_res (out_tuser[0]),
    .out_kind      (out_tuser[1]),
    .out_bam       (out_tdata)
  );

  // unhandled reports come out as zero compass angles
  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 16'h0000 && !out_tuser[1]))
    else $error("invalid result carries a nonzero angle or yaw kind");

  // an empty output register lets the whole pipeline move
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register is empty");

  // nothing is presented right after reset
  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule
